### hdl/sst_pkg.sv
package sst_pkg;

    // Node capacity and derived widths
    localparam int MAX_NODES  = 32;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = $clog2(MAX_NODES + 1);

    // Port field widths
    localparam int VALUE_W    = 17;
    localparam int CFG_W      = 6;
    localparam int NODE_OUT_W = 5;
    localparam int LEN_OUT_W  = 6;

    // One half in 16-fraction-bit fixed point
    localparam logic [VALUE_W-1:0] HALF_FIXED = 17'd32768;

    // Node count after reset
    localparam logic [CFG_W-1:0] RESET_NODE_COUNT = 6'd32;

    // Edge matrix write request
    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] row;
        logic [NODE_W-1:0] col;
        logic              bit_val;
    } edge_wr_t;

endpackage

### hdl/sst_edge_store.sv
module sst_edge_store (
    input  logic                          clk,
    input  sst_pkg::edge_wr_t             wr,
    input  logic [sst_pkg::NODE_W-1:0]    rd_row,
    output logic [sst_pkg::MAX_NODES-1:0] rd_bits
);

    // One row of edge bits per node; contents undefined until loaded
    logic [sst_pkg::MAX_NODES-1:0] edge_reg [sst_pkg::MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            edge_reg[wr.row][wr.col] <= wr.bit_val;
        end
    end

    // Row of the node currently being walked
    assign rd_bits = edge_reg[rd_row];

endmodule

### hdl/sst_lowbit.sv
module sst_lowbit (
    input  logic [sst_pkg::MAX_NODES-1:0] word,
    output logic                          found,
    output logic [sst_pkg::NODE_W-1:0]    index
);

    logic [sst_pkg::MAX_NODES-1:0] low_onehot;

    // Isolate the lowest set bit, then encode its position
    always_comb
    begin
        low_onehot = word & (~word + sst_pkg::MAX_NODES'(1));
        index      = '0;
        for (int b = 0; b < sst_pkg::NODE_W; b++)
        begin
            for (int i = 0; i < sst_pkg::MAX_NODES; i++)
            begin
                if (((i >> b) & 1) != 0)
                begin
                    index[b] = index[b] | low_onehot[i];
                end
            end
        end
    end

    assign found = |word;

endmodule

### hdl/sst_order_ram.sv
module sst_order_ram (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [sst_pkg::NODE_W-1:0] wr_addr,
    input  logic [sst_pkg::NODE_W-1:0] wr_data,
    input  logic [sst_pkg::NODE_W-1:0] rd_addr,
    output logic [sst_pkg::NODE_W-1:0] rd_data
);

    // Walk order, one node index per walk position
    logic [sst_pkg::NODE_W-1:0] mem [sst_pkg::MAX_NODES];
    logic [sst_pkg::NODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/shortest_subtour_finder_core.sv
// Matrix entries are taken one per cycle while busy is low. The last of n*n entries
// starts the walk: each chain opens in the start state and is walked with
// the shared lowest-bit search unit; then the subtour streams out one node per cycle,
// read from the registered order RAM. Busy is high from the cycle after the last entry
// until the last node shows. The receiver cannot stall.
// Reset (rst_n, async, low): loading restarts at entry 0, node count 32, no output.
module shortest_subtour_finder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [sst_pkg::VALUE_W-1:0]      entry_value,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sst_pkg::CFG_W-1:0]        cfg_data,
    output logic                             result_strobe,
    output logic [sst_pkg::NODE_OUT_W-1:0]   tour_node,
    output logic [sst_pkg::LEN_OUT_W-1:0]    tour_length,
    output logic                             last_node
);

    localparam int MAXN   = sst_pkg::MAX_NODES;
    localparam int NODE_W = sst_pkg::NODE_W;
    localparam int CNT_W  = sst_pkg::CNT_W;
    localparam int CFG_W  = sst_pkg::CFG_W;

    // Sequencer states
    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]        state_reg,       state_next;
    logic [CFG_W-1:0]  cfg_nodes_reg,   cfg_nodes_next;
    logic [NODE_W-1:0] row_reg,         row_next;
    logic [NODE_W-1:0] col_reg,         col_next;
    logic [MAXN-1:0]   visited_reg,     visited_next;
    logic [NODE_W-1:0] node_reg,        node_next;
    logic [CNT_W-1:0]  len_reg,         len_next;
    logic [CNT_W-1:0]  pos_reg,         pos_next;
    logic [CNT_W-1:0]  chain_start_reg, chain_start_next;
    logic [NODE_W-1:0] best_start_reg,  best_start_next;
    logic [CNT_W-1:0]  best_len_reg,    best_len_next;
    logic [CNT_W-1:0]  emit_k_reg,      emit_k_next;
    logic              strobe_reg,      strobe_next;
    logic              last_reg,        last_next;

    logic [CFG_W:0]    cfg_ext;
    logic [CNT_W-1:0]  n_active;
    logic [NODE_W-1:0] n_last;
    logic [MAXN-1:0]   active_mask;
    logic [MAXN-1:0]   row_bits;
    logic [MAXN-1:0]   visited_new;
    logic [MAXN-1:0]   ff_word;
    logic              ff_found;
    logic [NODE_W-1:0] ff_index;
    logic [CNT_W-1:0]  len_new;
    logic              load_accept;
    logic              ram_wr_en;
    logic [NODE_W-1:0] ram_rd_addr;
    logic [NODE_W-1:0] ram_rd_data;
    sst_pkg::edge_wr_t edge_wr;

    // Clamp node count into 1..MAX_NODES
    always_comb
    begin
        cfg_ext = {1'b0, cfg_nodes_reg};
        if (cfg_ext == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (cfg_ext > (CFG_W + 1)'(MAXN))
        begin
            n_active = CNT_W'(MAXN);
        end
        else
        begin
            n_active = CNT_W'(cfg_ext);
        end
    end

    assign n_last = NODE_W'(n_active - CNT_W'(1));

    always_comb
    begin
        for (int i = 0; i < MAXN; i++)
        begin
            active_mask[i] = (CNT_W'(i) < n_active);
        end
    end

    // Shared search operand: unseen neighbors while walking, unseen nodes otherwise
    assign visited_new = visited_reg | (MAXN'(1) << node_reg);
    assign ff_word     = (state_reg == ST_WALK) ? (row_bits & ~visited_new & active_mask)
                                                : (~visited_reg & active_mask);
    assign len_new     = len_reg + CNT_W'(1);
    assign load_accept = start && (state_reg == ST_LOAD);

    // Edge bit write for each accepted entry
    assign edge_wr.en      = load_accept;
    assign edge_wr.row     = row_reg;
    assign edge_wr.col     = col_reg;
    assign edge_wr.bit_val = (entry_value > sst_pkg::HALF_FIXED);

    assign ram_wr_en   = (state_reg == ST_WALK);
    assign ram_rd_addr = best_start_reg + emit_k_reg[NODE_W-1:0];

    sst_edge_store u_edges (
        .clk     (clk),
        .wr      (edge_wr),
        .rd_row  (node_reg),
        .rd_bits (row_bits)
    );

    sst_lowbit u_search (
        .word  (ff_word),
        .found (ff_found),
        .index (ff_index)
    );

    sst_order_ram u_order (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg[NODE_W-1:0]),
        .wr_data (node_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cfg_nodes_next   = cfg_nodes_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        visited_next     = visited_reg;
        node_next        = node_reg;
        len_next         = len_reg;
        pos_next         = pos_reg;
        chain_start_next = chain_start_reg;
        best_start_next  = best_start_reg;
        best_len_next    = best_len_reg;
        emit_k_next      = emit_k_reg;
        strobe_next      = 1'b0;
        last_next        = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (load_accept)
                begin
                    if (col_reg == n_last)
                    begin
                        col_next = '0;
                        if (row_reg == n_last)
                        begin
                            row_next        = '0;
                            visited_next    = '0;
                            pos_next        = '0;
                            best_start_next = '0;
                            best_len_next   = n_active + CNT_W'(1);
                            state_next      = ST_START;
                        end
                        else
                        begin
                            row_next = row_reg + NODE_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + NODE_W'(1);
                    end
                end
            end
            ST_START:
            begin
                // lowest unseen node opens the next chain
                if (ff_found)
                begin
                    node_next        = ff_index;
                    len_next         = '0;
                    chain_start_next = pos_reg;
                    state_next       = ST_WALK;
                end
                else
                begin
                    emit_k_next = '0;
                    state_next  = ST_EMIT;
                end
            end
            ST_WALK:
            begin
                visited_next = visited_new;
                len_next     = len_new;
                pos_next     = pos_reg + CNT_W'(1);
                if (!ff_found || (len_new >= n_active))
                begin
                    // chain ends; earliest shortest wins
                    if (len_new < best_len_reg)
                    begin
                        best_len_next   = len_new;
                        best_start_next = chain_start_reg[NODE_W-1:0];
                    end
                    state_next = ST_START;
                end
                else
                begin
                    node_next = ff_index;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                last_next   = ((emit_k_reg + CNT_W'(1)) == best_len_reg);
                emit_k_next = emit_k_reg + CNT_W'(1);
                if ((emit_k_reg + CNT_W'(1)) == best_len_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // Node count write restarts loading
        if (cfg_valid && cfg_ready)
        begin
            cfg_nodes_next = cfg_data;
            row_next       = '0;
            col_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            cfg_nodes_reg   <= sst_pkg::RESET_NODE_COUNT;
            row_reg         <= '0;
            col_reg         <= '0;
            visited_reg     <= '0;
            node_reg        <= '0;
            len_reg         <= '0;
            pos_reg         <= '0;
            chain_start_reg <= '0;
            best_start_reg  <= '0;
            best_len_reg    <= CNT_W'(MAXN + 1);
            emit_k_reg      <= '0;
            strobe_reg      <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cfg_nodes_reg   <= cfg_nodes_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            visited_reg     <= visited_next;
            node_reg        <= node_next;
            len_reg         <= len_next;
            pos_reg         <= pos_next;
            chain_start_reg <= chain_start_next;
            best_start_reg  <= best_start_next;
            best_len_reg    <= best_len_next;
            emit_k_reg      <= emit_k_next;
            strobe_reg      <= strobe_next;
            last_reg        <= last_next;
        end
    end

    // Outputs
    assign busy          = (state_reg != ST_LOAD);
    assign cfg_ready     = (state_reg == ST_LOAD);
    assign result_strobe = strobe_reg;
    assign last_node     = last_reg;
    assign tour_node     = sst_pkg::NODE_OUT_W'(ram_rd_data);
    assign tour_length   = sst_pkg::LEN_OUT_W'(best_len_reg);

    // Assertions
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result transfer without a preceding busy cycle");

    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_node |-> result_strobe)
        else $error("last node marked outside a result transfer");

    a_emit_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_node) |=> result_strobe)
        else $error("subtour emission broke off before its last node");

endmodule
